[rtl/core/lsal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsal_pkg
// Constants and helpers for the auto-ranging light sensor lux core.
// ----------------------------------------------------------------------------
package lsal_pkg;

    localparam int CountW = 16;
    localparam int LuxW   = 25;
    localparam int GainW  = 2;
    localparam int IntW   = 3;
    localparam int ConfW  = 11;
    localparam int ShW    = 4;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 3;

    localparam logic [CfgIdxW-1:0] CFG_AUTORANGE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INTEG     = 2'd2;

    localparam logic [CountW-1:0] SAT_LIMIT = 16'hFF00;
    localparam logic [CountW-1:0] LOW_LIMIT = 16'd100;

    localparam logic [GainW-1:0] GAIN_EIGHTH  = 2'b00;
    localparam logic [GainW-1:0] GAIN_QUARTER = 2'b01;
    localparam logic [GainW-1:0] GAIN_ONE     = 2'b10;
    localparam logic [GainW-1:0] GAIN_TWO     = 2'b11;

    localparam logic [IntW-1:0] INT_25MS  = 3'd0;
    localparam logic [IntW-1:0] INT_100MS = 3'd2;
    localparam logic [IntW-1:0] INT_800MS = 3'd5;

    // lux_q8 = floor(count * 294912/625) >> (9 - s), s = log2(gain mul * time mul).
    // K = ceil(294912 * 2^26 / 625); its overshoot stays below one step of 1/625.
    localparam int              RecipShift = 26;
    localparam int              RecipW     = 35;
    localparam logic [RecipW-1:0] RECIP_K  = 35'd31665934880;
    localparam logic [ShW-1:0]  MAX_SCALE  = 4'd9;

    localparam int ProdW = CountW + RecipW;

    typedef logic [ShW-1:0] t_sh;

    function automatic t_sh gain_log(input logic [GainW-1:0] g);
        t_sh v;
        case (g)
            GAIN_EIGHTH:  v = 4'd4;
            GAIN_QUARTER: v = 4'd3;
            GAIN_ONE:     v = 4'd1;
            GAIN_TWO:     v = 4'd0;
            default:      v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic t_sh time_log(input logic [IntW-1:0] it);
        t_sh v;
        if (it > INT_800MS) begin
            v = 4'd0;
        end else begin
            v = t_sh'(INT_800MS - it);
        end
        return v;
    endfunction

    function automatic logic [ConfW-1:0] conf_of(input logic [GainW-1:0] g,
                                                  input logic [IntW-1:0]  it);
        logic [1:0] gc;
        case (g)
            GAIN_EIGHTH:  gc = 2'd3;
            GAIN_QUARTER: gc = 2'd2;
            GAIN_ONE:     gc = 2'd0;
            GAIN_TWO:     gc = 2'd1;
            default:      gc = 2'd0;
        endcase
        return {gc, 2'b00, it, 4'b0000};
    endfunction

endpackage
`default_nettype wire

[rtl/core/light_sensor_autorange_lux_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_core
// Converts raw ambient light counts to lux and steps the sensor range ladder.
// ----------------------------------------------------------------------------
// Each accepted word passes an input register and a result register, moving on
// to the result register unless a stalled result is held there; a new word can be
// taken every cycle while the result side keeps up. The path between the two is
// one constant multiply (count by a fixed reciprocal of the 0.0576 lux scale) and
// a right shift set by the running gain and integration time; lux uses the
// setting in force when the sample was taken, and the range step lands on the
// running setting as the word moves to the result register. Configuration writes
// are taken at any time and are meant to happen while the core is idle.
module light_sensor_autorange_lux_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [15:0] als_count
    input  wire logic        i_s_axis_tuser,   // [0] read_ok

    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // [24:0] lux_q8, [35:25] conf_word,
                                               // [37:36] gain_now,
                                               // [40:38] integration_now, zero above
    output logic [1:0]       o_m_axis_tuser,   // [0] status, [1] conf_changed

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [lsal_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [lsal_pkg::CfgDataW-1:0] i_cfg_data
);

    logic                          r_v1;
    logic [lsal_pkg::CountW-1:0]   r_count;
    logic                          r_ok;

    logic                          r_auto;
    logic [lsal_pkg::GainW-1:0]    r_gain;
    logic [lsal_pkg::IntW-1:0]     r_integ;

    logic                          r_ov;
    logic [lsal_pkg::LuxW-1:0]     r_lux;
    logic                          r_status;
    logic [lsal_pkg::ConfW-1:0]    r_conf;
    logic                          r_changed;
    logic [lsal_pkg::GainW-1:0]    r_gain_now;
    logic [lsal_pkg::IntW-1:0]     r_integ_now;

    logic                          adv;
    logic                          cfg_wr;
    logic [lsal_pkg::ProdW-1:0]    prod;
    logic [lsal_pkg::LuxW-1:0]     lux_full;
    lsal_pkg::t_sh                 scale;
    lsal_pkg::t_sh                 sh;
    logic [lsal_pkg::LuxW-1:0]     n_lux;
    logic [lsal_pkg::GainW-1:0]    n_gain;
    logic [lsal_pkg::IntW-1:0]     n_integ;
    logic                          n_changed;
    logic [lsal_pkg::IntW-1:0]     cfg_integ;

    assign adv             = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = !r_v1 || adv;
    assign o_cfg_ready     = 1'b1;
    assign cfg_wr          = i_cfg_valid;

    assign prod     = lsal_pkg::ProdW'(r_count) * lsal_pkg::ProdW'(lsal_pkg::RECIP_K);
    assign lux_full = prod[lsal_pkg::RecipShift +: lsal_pkg::LuxW];
    assign scale    = lsal_pkg::gain_log(r_gain) + lsal_pkg::time_log(r_integ);
    assign sh       = lsal_pkg::MAX_SCALE - scale;
    assign n_lux    = r_ok ? (lux_full >> sh) : '0;

    always_comb begin
        n_gain    = r_gain;
        n_integ   = r_integ;
        n_changed = 1'b0;
        if (r_ok && r_auto) begin
            if (r_count > lsal_pkg::SAT_LIMIT) begin
                if (r_gain != lsal_pkg::GAIN_EIGHTH) begin
                    n_gain    = r_gain - 2'd1;
                    n_changed = 1'b1;
                end else if (r_integ != lsal_pkg::INT_25MS) begin
                    n_integ   = r_integ - 3'd1;
                    n_changed = 1'b1;
                end
            end else if (r_count < lsal_pkg::LOW_LIMIT) begin
                if (r_gain != lsal_pkg::GAIN_TWO) begin
                    n_gain    = r_gain + 2'd1;
                    n_changed = 1'b1;
                end else if (r_integ < lsal_pkg::INT_800MS) begin
                    n_integ   = r_integ + 3'd1;
                    n_changed = 1'b1;
                end
            end
        end
    end

    assign cfg_integ = (i_cfg_data > lsal_pkg::INT_800MS) ? lsal_pkg::INT_800MS : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
            r_auto  <= 1'b0;
            r_gain  <= lsal_pkg::GAIN_ONE;
            r_integ <= lsal_pkg::INT_100MS;
        end else begin
            if (o_s_axis_tready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_ov <= r_v1;
            end
            if (adv && r_v1) begin
                r_gain  <= n_gain;
                r_integ <= n_integ;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    lsal_pkg::CFG_AUTORANGE: r_auto  <= i_cfg_data[0];
                    lsal_pkg::CFG_GAIN:      r_gain  <= i_cfg_data[lsal_pkg::GainW-1:0];
                    lsal_pkg::CFG_INTEG:     r_integ <= cfg_integ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_count <= i_s_axis_tdata;
            r_ok    <= i_s_axis_tuser;
        end
        if (adv && r_v1) begin
            r_lux       <= n_lux;
            r_status    <= !r_ok;
            r_conf      <= lsal_pkg::conf_of(n_gain, n_integ);
            r_changed   <= n_changed;
            r_gain_now  <= n_gain;
            r_integ_now <= n_integ;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {7'b0, r_integ_now, r_gain_now, r_conf, r_lux};
    assign o_m_axis_tuser  = {r_changed, r_status};

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && r_v1 && r_ov && !i_m_axis_tready))
        else $error("input register overwritten while stalled");

    a_err_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_m_axis_tuser[0]) |-> (!o_m_axis_tuser[1] && r_lux == '0))
        else $error("read error result carries lux or range change");

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ <= lsal_pkg::INT_800MS)
        else $error("running integration code out of range");

    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v1) |=> (r_gain_now == r_gain && r_integ_now == r_integ))
        else $error("result setting differs from running setting");
`endif

endmodule
`default_nettype wire

[tb/lux_result_checker.sv]
// ----------------------------------------------------------------------------
// lux_result_checker
// Watches the sample, result and register channels of the lux core, predicts
// each result word from its own copy of the range state, and compares every
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lux_result_checker
    import lsal_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    input  wire logic [15:0]         i_s_tdata,
    input  wire logic                i_s_tuser,

    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [47:0]         i_m_tdata,
    input  wire logic [1:0]          i_m_tuser,

    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,

    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [LuxW-1:0]  lux_q8;
        logic             status;
        logic [ConfW-1:0] conf_word;
        logic             conf_changed;
        logic [GainW-1:0] gain_now;
        logic [IntW-1:0]  integ_now;
    } lux_reading_t;

    lux_reading_t     pending_readings[$];
    lux_reading_t     next_reading;
    lux_reading_t     want;
    lux_reading_t     got;
    logic             auto_en;
    logic [GainW-1:0] run_gain;
    logic [IntW-1:0]  run_integ;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [LuxW-1:0] scale_to_lux(input logic [CountW-1:0] cnt,
                                                     input logic [GainW-1:0]  g,
                                                     input logic [IntW-1:0]   it);
        longint unsigned gm;
        longint unsigned tm;
        longint unsigned prod;
        case (g)
            GAIN_EIGHTH:  gm = 16;
            GAIN_QUARTER: gm = 8;
            GAIN_ONE:     gm = 2;
            default:      gm = 1;
        endcase
        tm   = (it > INT_800MS) ? 64'd1 : (64'd32 >> it);
        prod = (64'(cnt) * 64'd9216 * gm * tm) / 64'd10000;
        return prod[LuxW-1:0];
    endfunction

    function automatic logic [ConfW-1:0] sensor_word(input logic [GainW-1:0] g,
                                                     input logic [IntW-1:0]  it);
        logic [ConfW-1:0] gc;
        case (g)
            GAIN_EIGHTH:  gc = 3;
            GAIN_QUARTER: gc = 2;
            GAIN_ONE:     gc = 0;
            default:      gc = 1;
        endcase
        return (ConfW'(it) << 4) | (gc << 9);
    endfunction

    function automatic lux_reading_t predict_reading(input logic [CountW-1:0] cnt,
                                                     input logic              ok,
                                                     input logic              en,
                                                     input logic [GainW-1:0]  g_in,
                                                     input logic [IntW-1:0]   it_in);
        lux_reading_t     r;
        logic [GainW-1:0] g;
        logic [IntW-1:0]  it;
        logic             chg;
        r   = '0;
        g   = g_in;
        it  = it_in;
        chg = 1'b0;
        if (ok) begin
            r.lux_q8 = scale_to_lux(cnt, g, it);
            if (en) begin
                if (cnt > SAT_LIMIT) begin
                    if (g != GAIN_EIGHTH) begin
                        g   = g - 1'b1;
                        chg = 1'b1;
                    end else if (it != INT_25MS) begin
                        it  = it - 1'b1;
                        chg = 1'b1;
                    end
                end else if (cnt < LOW_LIMIT) begin
                    if (g != GAIN_TWO) begin
                        g   = g + 1'b1;
                        chg = 1'b1;
                    end else if (it < INT_800MS) begin
                        it  = it + 1'b1;
                        chg = 1'b1;
                    end
                end
            end
        end
        r.status       = ~ok;
        r.conf_word    = sensor_word(g, it);
        r.conf_changed = chg;
        r.gain_now     = g;
        r.integ_now    = it;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("mismatch at %0t: %s expected 'h%0h got 'h%0h", $realtime, what,
                 exp_v, got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            auto_en   = 1'b0;
            run_gain  = GAIN_ONE;
            run_integ = INT_100MS;
            pending_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AUTORANGE: auto_en  = i_cfg_data[0];
                    CFG_GAIN:      run_gain = i_cfg_data[GainW-1:0];
                    CFG_INTEG:     run_integ = (i_cfg_data > INT_800MS) ? INT_800MS
                                                                        : i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                next_reading = predict_reading(i_s_tdata, i_s_tuser, auto_en,
                                               run_gain, run_integ);
                pending_readings.push_back(next_reading);
                run_gain  = next_reading.gain_now;
                run_integ = next_reading.integ_now;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("unexpected result word", 0, i_m_tdata);
                end else begin
                    want             = pending_readings.pop_front();
                    got.lux_q8       = i_m_tdata[24:0];
                    got.conf_word    = i_m_tdata[35:25];
                    got.gain_now     = i_m_tdata[37:36];
                    got.integ_now    = i_m_tdata[40:38];
                    got.status       = i_m_tuser[0];
                    got.conf_changed = i_m_tuser[1];
                    if (got.lux_q8 != want.lux_q8)
                        report_mismatch("lux_q8", want.lux_q8, got.lux_q8);
                    if (got.status != want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.conf_word != want.conf_word)
                        report_mismatch("conf_word", want.conf_word, got.conf_word);
                    if (got.conf_changed != want.conf_changed)
                        report_mismatch("conf_changed", want.conf_changed,
                                        got.conf_changed);
                    if (got.gain_now != want.gain_now)
                        report_mismatch("gain_now", want.gain_now, got.gain_now);
                    if (got.integ_now != want.integ_now)
                        report_mismatch("integration_now", want.integ_now,
                                        got.integ_now);
                end
            end
        end
        o_pending = pending_readings.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the auto-ranging lux core: directed samples at the
// count thresholds and ladder ends, then random runs of dark, saturated and
// mixed samples over several register settings, with random stalls on both
// stream sides. A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import lsal_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic [15:0]         i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                i_m_axis_tready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    wire logic           o_s_axis_tready;
    wire logic           o_m_axis_tvalid;
    wire logic [47:0]    o_m_axis_tdata;
    wire logic [1:0]     o_m_axis_tuser;
    wire logic           o_cfg_ready;
    int                  chk_fail_count;
    int                  chk_pending;
    bit                  calm = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    light_sensor_autorange_lux_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    lux_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // hold valid after the handshake; the caller drops it or sends again
    task automatic push_sample(input logic [15:0] cnt, input logic ok);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = cnt;
        i_s_axis_tuser  = ok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // drain every pending result before touching a register
    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] val);
        i_s_axis_tvalid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : sink
        int gap;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            i_m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #8000000;
        $display("light_sensor_autorange_lux_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int             sent;
        int             mode;
        int             run_len;
        logic [15:0]    cnt;
        logic           ok;
        logic [2:0]     cfg_val;
        logic [2:0]     gain_val;
        logic [2:0]     integ_val;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ranging off after reset: no step at any count
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd50, 1'b1);

        // top of the ladder: dark counts change nothing
        write_register(CFG_AUTORANGE, 3'b001);
        write_register(CFG_GAIN, 3'b011);
        write_register(CFG_INTEG, 3'b101);
        push_sample(16'h0000, 1'b1);
        push_sample(16'd99, 1'b1);
        // walk down: gain first, then integration time
        push_sample(16'hFF01, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFF, 1'b1);

        // oversized integration code clamps to the longest time
        write_register(CFG_INTEG, 3'b111);
        push_sample(16'd100, 1'b1);
        push_sample(16'hFF00, 1'b1);

        // bottom of the ladder: saturation changes nothing
        write_register(CFG_GAIN, 3'b100);
        write_register(CFG_INTEG, 3'b000);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'd99, 1'b1);

        write_register(CFG_UNUSED, 3'b111);
        write_register(CFG_INTEG, 3'b110);
        write_register(CFG_AUTORANGE, 3'b110);
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            calm    = (ph % 4 == 3);
            cfg_val = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 4) != 0) cfg_val[0] = 1'b1;
            write_register(CFG_AUTORANGE, cfg_val);
            if (ph == 0) begin
                gain_val  = 3'd0;
                integ_val = 3'd0;
            end else if (ph == 1) begin
                gain_val  = 3'd3;
                integ_val = 3'd5;
            end else begin
                gain_val  = 3'($urandom_range(0, 7));
                integ_val = 3'($urandom_range(0, 7));
            end
            write_register(CFG_GAIN, gain_val);
            write_register(CFG_INTEG, integ_val);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_UNUSED, 3'($urandom_range(0, 7)));

            sent = 0;
            while (sent < 65) begin
                mode    = $urandom_range(0, 9);
                run_len = $urandom_range(1, 16);
                if (run_len > 65 - sent) run_len = 65 - sent;
                repeat (run_len) begin
                    if (mode < 4) begin
                        cnt = 16'($urandom_range(0, 99));
                    end else if (mode < 7) begin
                        cnt = 16'($urandom_range(16'hFF01, 16'hFFFF));
                    end else if (mode == 7) begin
                        case ($urandom_range(0, 5))
                            0: cnt = 16'd99;
                            1: cnt = 16'd100;
                            2: cnt = 16'hFF00;
                            3: cnt = 16'hFF01;
                            4: cnt = 16'h0000;
                            default: cnt = 16'hFFFF;
                        endcase
                    end else begin
                        cnt = 16'($urandom_range(0, 16'hFFFF));
                    end
                    ok = ($urandom_range(0, 15) != 0);
                    push_sample(cnt, ok);
                    sent++;
                end
            end
        end

        i_s_axis_tvalid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (chk_fail_count == 0) begin
            $display("light_sensor_autorange_lux_core regression: pass");
        end else begin
            $display("light_sensor_autorange_lux_core regression: fail");
        end
        $finish;
    end

endmodule
